/* hdl/maoh_pkg.sv */
// shared types and constants of the moving-average obstacle unit
package maoh_pkg;

  localparam int unsigned MmW     = 16;
  localparam int unsigned CmW     = 13;
  localparam int unsigned LenW    = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [MmW-1:0] NoEchoMm = 16'd9999;
  localparam int unsigned    CmToMm   = 10;

  localparam logic [LenW-1:0] WindowLenRst    = 5'd8;
  localparam logic [MmW-1:0]  WarningLevelRst = 16'd300;
  localparam logic [MmW-1:0]  DangerLevelRst  = 16'd150;
  localparam logic [MmW-1:0]  ClearLevelRst   = 16'd200;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWindowLen    = 2'd0,
    CfgWarningLevel = 2'd1,
    CfgDangerLevel  = 2'd2,
    CfgClearLevel   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OpSample = 1'b0,
    OpClear  = 1'b1
  } op_e;

endpackage

/* hdl/maoh_if.sv */
// valid/ready channel interfaces for readings and filtered results
interface maoh_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [maoh_pkg::MmW-1:0]     mm_reading;
  logic [maoh_pkg::CmW-1:0]     cm_reading;

  modport source (output valid, op, mm_reading, cm_reading, input ready);
  modport sink   (input valid, op, mm_reading, cm_reading, output ready);
endinterface

interface maoh_out_if;
  logic                         valid;
  logic                         ready;
  logic [maoh_pkg::MmW-1:0]     avg_distance;
  logic                         obstacle;
  logic                         warning;

  modport source (output valid, avg_distance, obstacle, warning, input ready);
  modport sink   (input valid, avg_distance, obstacle, warning, output ready);
endinterface

/* hdl/maoh_ram.sv */
// generic single-write, single-read ram with registered read data
module maoh_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/maoh_div.sv */
// restoring divider, one quotient bit per cycle
module maoh_div #(
  parameter int unsigned DvdW = 20,
  parameter int unsigned DvsW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o
);

  localparam int unsigned CntW = (DvdW > 1) ? $clog2(DvdW) : 1;

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dvd_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW:0]   rem_sh;
  logic            fits;

  assign rem_sh = {rem_q, dvd_q[DvdW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // quotient bits shift into the dividend register from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], fits};
      rem_q <= fits ? DvsW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DvsW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

/* hdl/moving_average_obstacle_hysteresis_unit.sv */
// moving-average obstacle detector with hysteresis on the filtered distance
//
// in_i takes one word per reading: op selects a new sample or a clear, with
// the mm and cm readings. out_o gives one word per accepted input: filtered
// distance, obstacle flag and warning. Both are valid/ready channels.
// The sample window lives in a one-port-read, one-port-write ram; each
// sample does a read of the slot to be replaced, a write-back and a sum
// update, then a restoring divide by the window length, one bit per cycle.
// A sample goes from accept through the read, divide and output states to
// its result, and the next word is taken once the result is loaded into the
// output register; a clear or a window length of zero skips the read and
// divide and goes straight to the output state.
// One item is in flight at a time; in_i.ready is high only while idle.
// The result sits in an output register, so a stalled out_o holds the word
// and the next input is still taken; a second result waits until it drains.
// Reset clears the window (per-slot valid bits), sum, slot and flag at once
// and loads the thresholds with their defaults; no clearing pass is needed.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.
module moving_average_obstacle_hysteresis_unit #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [maoh_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [maoh_pkg::CfgW-1:0]       cfg_data_i,
  maoh_in_if.sink                         in_i,
  maoh_out_if.source                      out_o
);

  localparam int unsigned MmW    = maoh_pkg::MmW;
  localparam int unsigned LenW   = maoh_pkg::LenW;
  localparam int unsigned AddrW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SumW   = MmW + $clog2(MAX_WINDOW);
  localparam int unsigned LenCap = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
  localparam int unsigned CmpW   = (AddrW > LenW) ? AddrW + 1 : LenW + 1;
  localparam int unsigned ProdW  = maoh_pkg::CmW + 4;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StDiv,
    StOut
  } state_e;

  state_e state_q;

  // configuration
  logic [LenW-1:0] window_len_q;
  logic [MmW-1:0]  warning_level_q;
  logic [MmW-1:0]  danger_level_q;
  logic [MmW-1:0]  clear_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q    <= maoh_pkg::WindowLenRst;
      warning_level_q <= maoh_pkg::WarningLevelRst;
      danger_level_q  <= maoh_pkg::DangerLevelRst;
      clear_level_q   <= maoh_pkg::ClearLevelRst;
    end else if (cfg_we_i) begin
      case (maoh_pkg::cfg_idx_e'(cfg_idx_i))
        maoh_pkg::CfgWindowLen:    window_len_q    <= cfg_data_i[LenW-1:0];
        maoh_pkg::CfgWarningLevel: warning_level_q <= cfg_data_i[MmW-1:0];
        maoh_pkg::CfgDangerLevel:  danger_level_q  <= cfg_data_i[MmW-1:0];
        maoh_pkg::CfgClearLevel:   clear_level_q   <= cfg_data_i[MmW-1:0];
        default: ;
      endcase
    end
  end

  // window state
  logic [MAX_WINDOW-1:0] valid_q;
  logic [AddrW-1:0]      write_slot_q;
  logic [SumW-1:0]       sum_q;
  logic                  flag_q;
  logic [AddrW-1:0]      slot_q;
  logic [MmW-1:0]        sample_q;
  logic [LenW-1:0]       len_q;
  logic [MmW-1:0]        avg_q;

  logic                  out_valid_q;
  logic [MmW-1:0]        out_avg_q;
  logic                  out_obst_q;
  logic                  out_warn_q;

  logic                  in_acc;
  logic                  out_free;
  logic [LenW-1:0]       len;
  logic [AddrW-1:0]      slot_sel;
  logic [ProdW-1:0]      cm_mm;
  logic [MmW-1:0]        sample;
  logic [MmW-1:0]        old_val;
  logic [SumW-1:0]       sum_d;
  logic [CmpW-1:0]       slot_inc;
  logic [AddrW-1:0]      slot_d;
  logic                  flag_d;
  logic                  warn_d;
  logic [MmW-1:0]        ram_rdata;
  logic                  div_done;
  logic [SumW-1:0]       div_quot;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign len = (window_len_q > LenW'(LenCap)) ? LenW'(LenCap) : window_len_q;

  // a slot left beyond a shrunk window restarts at zero
  assign slot_sel = (CmpW'(write_slot_q) < CmpW'(len)) ? write_slot_q : '0;

  assign cm_mm  = ProdW'(in_i.cm_reading) * ProdW'(maoh_pkg::CmToMm);
  assign sample = (in_i.mm_reading != '0) ? in_i.mm_reading :
                  (in_i.cm_reading == '0) ? maoh_pkg::NoEchoMm :
                  (cm_mm > ProdW'({MmW{1'b1}})) ? {MmW{1'b1}} : cm_mm[MmW-1:0];

  // never-written slots read as zero
  assign old_val  = valid_q[slot_q] ? ram_rdata : '0;
  assign sum_d    = sum_q - SumW'(old_val) + SumW'(sample_q);
  assign slot_inc = CmpW'(slot_q) + 1'b1;
  assign slot_d   = (slot_inc >= CmpW'(len_q)) ? '0 : slot_inc[AddrW-1:0];

  always_comb begin
    flag_d = flag_q;
    if (flag_q) begin
      if (avg_q > clear_level_q) begin
        flag_d = 1'b0;
      end
    end else if (avg_q != '0 && avg_q <= danger_level_q) begin
      flag_d = 1'b1;
    end
    warn_d = !flag_d && avg_q != '0 && avg_q > danger_level_q &&
             avg_q <= warning_level_q;
  end

  maoh_ram #(
    .Width (MmW),
    .Depth (MAX_WINDOW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (state_q == StRead),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (in_acc),
    .raddr_i (slot_sel),
    .rdata_o (ram_rdata)
  );

  maoh_div #(
    .DvdW (SumW),
    .DvsW (LenW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StRead),
    .dividend_i (sum_d),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      valid_q      <= '0;
      write_slot_q <= '0;
      sum_q        <= '0;
      flag_q       <= 1'b0;
      slot_q       <= '0;
      sample_q     <= '0;
      len_q        <= '0;
      avg_q        <= '0;
      out_valid_q  <= 1'b0;
      out_avg_q    <= '0;
      out_obst_q   <= 1'b0;
      out_warn_q   <= 1'b0;
    end else begin
      // the held word drains unless a new one is loaded in this cycle
      if (out_valid_q && out_o.ready && state_q != StOut) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (maoh_pkg::op_e'(in_i.op) == maoh_pkg::OpClear) begin
              valid_q      <= '0;
              write_slot_q <= '0;
              sum_q        <= '0;
              flag_q       <= 1'b0;
              avg_q        <= '0;
              state_q      <= StOut;
            end else if (len == '0) begin
              avg_q   <= sample;
              state_q <= StOut;
            end else begin
              slot_q   <= slot_sel;
              sample_q <= sample;
              len_q    <= len;
              state_q  <= StRead;
            end
          end
        end
        StRead: begin
          // old entry arrives now; write back and start the divide
          valid_q[slot_q] <= 1'b1;
          sum_q           <= sum_d;
          write_slot_q    <= slot_d;
          state_q         <= StDiv;
        end
        StDiv: begin
          if (div_done) begin
            avg_q   <= (div_quot > SumW'({MmW{1'b1}})) ? {MmW{1'b1}} : div_quot[MmW-1:0];
            state_q <= StOut;
          end
        end
        StOut: begin
          if (out_free) begin
            flag_q      <= flag_d;
            out_valid_q <= 1'b1;
            out_avg_q   <= avg_q;
            out_obst_q  <= flag_d;
            out_warn_q  <= warn_d;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_i.ready         = (state_q == StIdle);
  assign out_o.valid        = out_valid_q;
  assign out_o.avg_distance = out_avg_q;
  assign out_o.obstacle     = out_obst_q;
  assign out_o.warning      = out_warn_q;

endmodule

/* verif/tb.sv */
// testbench of the moving-average obstacle unit: directed and random readings, scoreboard check
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxWindow = 16;
  localparam int unsigned ClkHalf   = 10;
  localparam int unsigned MaxMm     = 65535;
  localparam int unsigned MmW       = maoh_pkg::MmW;
  localparam int unsigned CmW       = maoh_pkg::CmW;
  localparam int unsigned LenW      = maoh_pkg::LenW;
  localparam int unsigned CfgW      = maoh_pkg::CfgW;
  localparam int unsigned CfgIdxW   = maoh_pkg::CfgIdxW;

  typedef struct packed {
    logic [MmW-1:0] avg_distance;
    logic           obstacle;
    logic           warning;
  } distance_word_t;

  // predicts the filtered distance and flags, and checks the words that come out
  class distance_checker;
    logic [MmW-1:0]  store [MaxWindow];
    logic [3:0]      slot;
    logic [19:0]     sum;
    logic            obstacle;
    logic [LenW-1:0] win_len;
    logic [MmW-1:0]  warn_lvl;
    logic [MmW-1:0]  danger_lvl;
    logic [MmW-1:0]  clear_lvl;
    distance_word_t  pending_words [$];
    int unsigned     mismatches;

    function new();
      win_len    = maoh_pkg::WindowLenRst;
      warn_lvl   = maoh_pkg::WarningLevelRst;
      danger_lvl = maoh_pkg::DangerLevelRst;
      clear_lvl  = maoh_pkg::ClearLevelRst;
      mismatches = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (store[i]) store[i] = '0;
      slot     = '0;
      sum      = '0;
      obstacle = 1'b0;
    endfunction

    function void set_reg(maoh_pkg::cfg_idx_e idx, logic [CfgW-1:0] data);
      case (idx)
        maoh_pkg::CfgWindowLen:    win_len    = data[LenW-1:0];
        maoh_pkg::CfgWarningLevel: warn_lvl   = data;
        maoh_pkg::CfgDangerLevel:  danger_lvl = data;
        maoh_pkg::CfgClearLevel:   clear_lvl  = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction

    function void note_reading(maoh_pkg::op_e op, logic [MmW-1:0] mm, logic [CmW-1:0] cm);
      int unsigned    sample;
      int unsigned    len;
      int unsigned    idx;
      int unsigned    total;
      int unsigned    avg;
      distance_word_t w;
      if (op == maoh_pkg::OpClear) begin
        clear_window();
        w = '0;
        pending_words.push_back(w);
        return;
      end
      if (mm != '0) begin
        sample = mm;
      end else if (cm == '0) begin
        sample = maoh_pkg::NoEchoMm;
      end else begin
        sample = int'(cm) * maoh_pkg::CmToMm;
        if (sample > MaxMm) sample = MaxMm;
      end
      len = (win_len > MaxWindow) ? MaxWindow : win_len;
      if (len == 0) begin
        avg = sample;
      end else begin
        // a slot left beyond a shrunk window restarts at the front
        idx        = (slot < len) ? slot : 0;
        total      = sum - store[idx] + sample;
        sum        = total[19:0];
        store[idx] = sample[MmW-1:0];
        slot       = (idx + 1 >= len) ? 4'd0 : 4'(idx + 1);
        avg        = total / len;
        if (avg > MaxMm) avg = MaxMm;
      end
      if (obstacle) begin
        if (avg > clear_lvl) obstacle = 1'b0;
      end else if (avg > 0 && avg <= danger_lvl) begin
        obstacle = 1'b1;
      end
      w.avg_distance = avg[MmW-1:0];
      w.obstacle     = obstacle;
      w.warning      = !obstacle && avg > 0 && avg > danger_lvl && avg <= warn_lvl;
      pending_words.push_back(w);
    endfunction

    function void check_result(distance_word_t got);
      distance_word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word avg %0d obstacle %0b warning %0b", $time,
                   got.avg_distance, got.obstacle, got.warning);
        return;
      end
      want = pending_words.pop_front();
      if (got.avg_distance !== want.avg_distance || got.obstacle !== want.obstacle ||
          got.warning !== want.warning) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch expected avg %0d obstacle %0b warning %0b,",
                    " got avg %0d obstacle %0b warning %0b"},
                   $time, want.avg_distance, want.obstacle, want.warning,
                   got.avg_distance, got.obstacle, got.warning);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  maoh_in_if  in_ch ();
  maoh_out_if out_ch ();

  moving_average_obstacle_hysteresis_unit #(
    .MAX_WINDOW (MaxWindow)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  distance_checker board;
  int unsigned     src_idle_pct;
  int unsigned     rx_idle_pct;
  logic [MmW-1:0]  target_mm;

  initial clk_i = 1'b0;
  always #(ClkHalf) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_result({out_ch.avg_distance, out_ch.obstacle, out_ch.warning});
  end

  // lowers valid, then waits for every outstanding word
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(maoh_pkg::cfg_idx_e idx, logic [CfgW-1:0] data);
    wait_drained();
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    board.set_reg(idx, data);
  endtask

  task automatic set_levels(logic [CfgW-1:0] win, logic [MmW-1:0] warn,
                            logic [MmW-1:0] danger, logic [MmW-1:0] clr);
    write_reg(maoh_pkg::CfgWindowLen, win);
    write_reg(maoh_pkg::CfgWarningLevel, warn);
    write_reg(maoh_pkg::CfgDangerLevel, danger);
    write_reg(maoh_pkg::CfgClearLevel, clr);
  endtask

  task automatic send_word(maoh_pkg::op_e op, logic [MmW-1:0] mm, logic [CmW-1:0] cm);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.mm_reading <= mm;
    in_ch.cm_reading <= cm;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    board.note_reading(op, mm, cm);
  endtask

  task automatic run_phase(logic [CfgW-1:0] win, logic [MmW-1:0] warn,
                           logic [MmW-1:0] danger, logic [MmW-1:0] clr, int unsigned n);
    int unsigned    roll;
    int             t;
    logic [MmW-1:0] mm;
    logic [CmW-1:0] cm;
    set_levels(win, warn, danger, clr);
    target_mm = danger;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(59) == 0) wait_drained();
      // the distance drifts around one of the thresholds so the flags toggle
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: target_mm = danger;
          1: target_mm = clr;
          2: target_mm = warn;
          default: target_mm = MmW'($urandom_range(MaxMm));
        endcase
      end
      roll = $urandom_range(99);
      cm   = CmW'($urandom_range(8191));
      if (roll < 5) begin
        send_word(maoh_pkg::OpClear, MmW'($urandom_range(MaxMm)), cm);
      end else if (roll < 15) begin
        if ($urandom_range(3) == 0) cm = '0;
        send_word(maoh_pkg::OpSample, '0, cm);
      end else if (roll < 25) begin
        send_word(maoh_pkg::OpSample, MmW'($urandom_range(MaxMm)), cm);
      end else begin
        t = int'(target_mm) + int'($urandom_range(60)) - 30;
        if (t < 0) t = 0;
        if (t > int'(MaxMm)) t = int'(MaxMm);
        mm = t[MmW-1:0];
        send_word(maoh_pkg::OpSample, mm, cm);
      end
    end
  endtask

  initial begin
    int unsigned danger;
    board            = new();
    src_idle_pct     = 21;
    rx_idle_pct      = 50;
    target_mm        = '0;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.op         = maoh_pkg::OpSample;
    in_ch.mm_reading = '0;
    in_ch.cm_reading = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds, window of eight: field extremes and the cm fallback
    send_word(maoh_pkg::OpSample, 16'd1, 13'd0);
    send_word(maoh_pkg::OpSample, 16'hFFFF, 13'd0);
    send_word(maoh_pkg::OpSample, 16'd0, 13'd0);
    send_word(maoh_pkg::OpSample, 16'd0, 13'd1);
    send_word(maoh_pkg::OpSample, 16'd0, 13'd6553);
    send_word(maoh_pkg::OpSample, 16'd0, 13'h1FFF);
    send_word(maoh_pkg::OpSample, 16'hFFFF, 13'h1FFF);
    send_word(maoh_pkg::OpClear, 16'd0, 13'd0);
    // raw pass-through makes the hysteresis edges exact
    write_reg(maoh_pkg::CfgWindowLen, 16'd0);
    send_word(maoh_pkg::OpSample, 16'd150, 13'd0);
    send_word(maoh_pkg::OpSample, 16'd200, 13'd0);
    send_word(maoh_pkg::OpSample, 16'd201, 13'd0);
    send_word(maoh_pkg::OpSample, 16'd151, 13'd0);
    send_word(maoh_pkg::OpSample, 16'd300, 13'd0);
    send_word(maoh_pkg::OpSample, 16'd301, 13'd0);
    send_word(maoh_pkg::OpSample, 16'd0, 13'd0);
    send_word(maoh_pkg::OpSample, 16'd100, 13'd0);
    send_word(maoh_pkg::OpClear, 16'hFFFF, 13'h1FFF);
    // length beyond the store is clamped, then the window shrinks over stale samples
    write_reg(maoh_pkg::CfgWindowLen, 16'd31);
    send_word(maoh_pkg::OpSample, 16'hFFFF, 13'd0);
    send_word(maoh_pkg::OpSample, 16'hFFFF, 13'd0);
    send_word(maoh_pkg::OpSample, 16'hFFFF, 13'd0);
    write_reg(maoh_pkg::CfgWindowLen, 16'd3);
    send_word(maoh_pkg::OpSample, 16'd10, 13'd0);
    send_word(maoh_pkg::OpSample, 16'd20, 13'd0);
    write_reg(maoh_pkg::CfgWindowLen, 16'd1);
    send_word(maoh_pkg::OpSample, 16'd5, 13'd0);
    send_word(maoh_pkg::OpClear, 16'd0, 13'd0);

    run_phase(16, 300, 150, 200, 115);
    danger = $urandom_range(20, 3000);
    run_phase(1, MmW'(danger + $urandom_range(1500)), MmW'(danger),
              MmW'(danger + $urandom_range(400)), 115);

    src_idle_pct = 50;
    rx_idle_pct  = 21;
    danger = $urandom_range(20, 3000);
    run_phase(0, MmW'(danger + $urandom_range(1500)), MmW'(danger),
              MmW'(danger + $urandom_range(400)), 115);
    run_phase(31, 16'hFFFF, 16'h0000, 16'h0000, 115);

    src_idle_pct = 0;
    rx_idle_pct  = 0;
    run_phase(CfgW'($urandom_range(2, 15)), 16'h0000, 16'hFFFF, 16'hFFFF, 115);
    danger = $urandom_range(20, 3000);
    run_phase(CfgW'($urandom_range(31)), MmW'($urandom_range(MaxMm)), MmW'(danger),
              MmW'(danger + $urandom_range(400)), 115);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("moving_average_obstacle_hysteresis_unit test passed");
    end else begin
      $display("moving_average_obstacle_hysteresis_unit test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("moving_average_obstacle_hysteresis_unit test failed");
    $finish;
  end

endmodule
